### sv/bma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants of the boxcar moving average core.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_W       = SAMPLE_BITS + 1;
  localparam int MAX_WINDOW_DEFAULT = 64;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int WW_W   = 7;
  localparam logic [WW_W-1:0] WINDOW_WIDTH_RESET = 7'd8;

  // word index of each register (paddr[2])
  localparam logic REG_WINDOW_WIDTH = 1'b0;
  localparam logic REG_HIGH_PASS    = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } bma_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    window_full;
  } bma_out_t;

endpackage

### sv/bma_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_divider
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero. The quotient holds until the next start.
// ----------------------------------------------------------------------------
module bma_divider #(
  parameter int SUM_W = 23,
  parameter int CNT_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic        [CNT_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  mag_q, mag_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;

  always_comb begin
    logic [CNT_W:0] trial;
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    step_d = step_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, mag_q[SUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      neg_d  = dividend_i[SUM_W-1];
      mag_d  = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = '0;
    end else if (busy_q) begin
      // restoring step: remainder always stays below the divisor
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
        mag_d = {mag_q[SUM_W-2:0], 1'b1};
      end else begin
        mag_d = {mag_q[SUM_W-2:0], 1'b0};
      end
      rem_d  = trial[CNT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

### sv/boxcar_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxcar_moving_average_core
// Boxcar moving average over a ring of recent samples, with an optional
// high-pass output (window midpoint minus average).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------
//  in       | input     | in_valid_i / in_stall_o    | bma_in_t  in_data_i
//  out      | output    | out_valid_o / out_stall_i  | bma_out_t out_data_o
//  config   | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  the result is loaded after the bit-serial divider of the running sum by
//  the count is done; the next item is taken only once the block is back
//  in ST_IDLE, so it works on one item at a time.
//  in_stall_o is high from accept until the result is loaded into the output
//  register; a stalled result only delays the load of the next one.
//  reset clears count, pointer and sum; the ring holds no reset.
// ----------------------------------------------------------------------------
module boxcar_moving_average_core #(
  parameter int MAX_WINDOW = bma_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bma_pkg::bma_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bma_pkg::bma_out_t            out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bma_pkg::ADDR_W-1:0]   paddr,
  input  logic [bma_pkg::DATA_W-1:0]   pwdata,
  output logic [bma_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int SB    = bma_pkg::SAMPLE_BITS;
  localparam int OW    = bma_pkg::OUT_W;
  localparam int WW    = bma_pkg::WW_W;
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SB + CNT_W;
  localparam int CMP_W = ((WW > CNT_W) ? WW : CNT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_UPDATE,
    ST_MID0,
    ST_MID1,
    ST_MID2,
    ST_WAIT
  } state_e;

  state_e                 state_q, state_d;
  logic [WW-1:0]          ww_q, ww_d;
  logic                   hp_q, hp_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SB-1:0]   x_q, x_d;
  logic signed [SB-1:0]   mid_a_q, mid_a_d;
  logic signed [SB-1:0]   mid_b_q, mid_b_d;
  logic                   out_valid_q, out_valid_d;
  bma_pkg::bma_out_t      out_data_q, out_data_d;

  logic signed [SB-1:0]   ring_mem [MAX_WINDOW];
  logic signed [SB-1:0]   rd_data_q;
  logic [PTR_W-1:0]       rd_addr, wr_addr;
  logic                   ring_we;

  logic [CNT_W-1:0]       w_eff;
  logic                   cfg_we;
  logic                   div_start, div_done;
  logic signed [SUM_W-1:0] div_quot;

  // position in the window, oldest first, to ring address
  function automatic logic [PTR_W-1:0] pos_addr(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] pos,
                                                input logic [CNT_W-1:0] w);
    logic [CNT_W:0] s;
    s = {1'b0, CNT_W'(ptr)} + {1'b0, pos};
    if (s >= {1'b0, w}) s = s - {1'b0, w};
    return s[PTR_W-1:0];
  endfunction

  // width zero acts as one, anything above the ring acts as the ring size
  always_comb begin
    logic [CMP_W-1:0] ww_ext;
    ww_ext = CMP_W'(ww_q);
    if (ww_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (ww_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = ww_ext[CNT_W-1:0];
    end
  end

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      bma_pkg::REG_WINDOW_WIDTH: prdata = bma_pkg::DATA_W'(ww_q);
      bma_pkg::REG_HIGH_PASS:    prdata = bma_pkg::DATA_W'(hp_q);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    logic [PTR_W-1:0]        ptr_n;
    logic [CNT_W-1:0]        cnt_n;
    logic signed [SUM_W-1:0] sum_n;
    logic [CNT_W-1:0]        nxt;
    logic [CNT_W-1:0]        half;
    logic signed [OW-1:0]    ab;
    logic signed [OW-1:0]    mid_v;
    logic signed [OW-1:0]    avg;
    state_d     = state_q;
    ww_d        = ww_q;
    hp_d        = hp_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    x_d         = x_q;
    mid_a_d     = mid_a_q;
    mid_b_d     = mid_b_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ring_we     = 1'b0;
    wr_addr     = ptr_q;
    rd_addr     = ptr_q;
    div_start   = 1'b0;
    ptr_n       = ptr_q;
    cnt_n       = cnt_q;
    sum_n       = sum_q;
    nxt         = CNT_W'(ptr_q) + 1'b1;
    half        = cnt_q >> 1;
    ab          = OW'(mid_a_q) + OW'(mid_b_q);
    mid_v       = OW'(mid_a_q);
    avg         = div_quot[OW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d = in_data_i.sample;
          if (in_data_i.restart) begin
            ptr_n = '0;
            cnt_n = '0;
            sum_n = '0;
          end
          if (CNT_W'(ptr_n) >= w_eff) ptr_n = '0;
          if (cnt_n > w_eff) begin
            ptr_n = '0;
            cnt_n = '0;
            sum_n = '0;
          end
          ptr_d   = ptr_n;
          cnt_d   = cnt_n;
          sum_d   = sum_n;
          state_d = ST_RD_OLD;
        end
      end
      ST_RD_OLD: begin
        // ring read of the oldest entry lands in rd_data_q
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        ring_we = 1'b1;
        if (cnt_q == w_eff) begin
          wr_addr = ptr_q;
          sum_d   = sum_q + SUM_W'(x_q) - SUM_W'(rd_data_q);
          ptr_d   = (nxt == w_eff) ? '0 : nxt[PTR_W-1:0];
        end else begin
          wr_addr = pos_addr(ptr_q, cnt_q, w_eff);
          cnt_d   = cnt_q + 1'b1;
          sum_d   = sum_q + SUM_W'(x_q);
        end
        div_start = 1'b1;
        state_d   = ST_MID0;
      end
      ST_MID0: begin
        rd_addr = pos_addr(ptr_q, half, w_eff);
        state_d = ST_MID1;
      end
      ST_MID1: begin
        mid_a_d = rd_data_q;
        rd_addr = pos_addr(ptr_q, half - 1'b1, w_eff);
        state_d = ST_MID2;
      end
      ST_MID2: begin
        mid_b_d = rd_data_q;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done && (!out_valid_q || !out_stall_i)) begin
          // even width: mean of the two middle entries, rounded down
          if (!w_eff[0] && (cnt_q > CNT_W'(1))) mid_v = ab >>> 1;
          out_data_d.filtered    = hp_q ? (mid_v - avg) : avg;
          out_data_d.window_full = (cnt_q == w_eff);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we) begin
      if (paddr[2] == bma_pkg::REG_WINDOW_WIDTH) begin
        ww_d  = pwdata[WW-1:0];
        ptr_d = '0;
        cnt_d = '0;
        sum_d = '0;
      end else begin
        hp_d = pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ww_q        <= bma_pkg::WINDOW_WIDTH_RESET;
      hp_q        <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ww_q        <= ww_d;
      hp_q        <= hp_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    mid_a_q    <= mid_a_d;
    mid_b_q    <= mid_b_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[wr_addr] <= x_q;
    rd_data_q <= ring_mem[rd_addr];
  end

  bma_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/bma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_checker
// Port-level checks of the boxcar moving average core, bound to the top level.
// ----------------------------------------------------------------------------
module bma_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bma_pkg::bma_out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item at a time: the block stalls right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears at the end of an item in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in progress");

  // midpoint minus average never reaches the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.filtered != {1'b1, {(bma_pkg::OUT_W-1){1'b0}}})
    else $error("filtered output out of range");

endmodule

bind boxcar_moving_average_core bma_checker u_bma_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boxcar moving average core. A short table of
// directed samples walks the extremes, the window width corner cases and both
// output modes. Random phases with fresh register settings follow. Every
// accepted sample runs through a behavioral filter model, and each result is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    bma_pkg::bma_in_t  item;
    bit                known;
    bma_pkg::bma_out_t want;
  } stim_t;

  typedef struct {
    bit                         set_cfg;
    logic [bma_pkg::WW_W-1:0]   w;
    bit                         hp;
    stim_t                      stim;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  bma_pkg::bma_in_t            in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  bma_pkg::bma_out_t           out_data;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [bma_pkg::ADDR_W-1:0]  paddr = '0;
  logic [bma_pkg::DATA_W-1:0]  pwdata = '0;
  logic [bma_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  boxcar_moving_average_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // filter model state
  logic signed [bma_pkg::SAMPLE_BITS-1:0] hist [bma_pkg::MAX_WINDOW_DEFAULT];
  int unsigned head, fill;
  longint      acc;
  logic [bma_pkg::WW_W-1:0] width_reg = bma_pkg::WINDOW_WIDTH_RESET;
  bit          hp_reg = 1'b0;

  stim_t                sample_queue [$];
  bma_pkg::bma_out_t    pending_outputs [$];
  dir_row_t             dir_table [$];
  stim_t                cur;
  bma_pkg::bma_out_t    next_want;
  bma_pkg::bma_out_t    got_want;

  int errors = 0, checked = 0, accepted = 0, settings = 0, holds = 0;
  int gap_max = 0, gap_left = 0, burst_left = 0;
  int stall_max = 0, run_left = 0, hold_left = 0;
  bit stalling = 1'b0, hold_req = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic void forget_history();
    head = 0;
    fill = 0;
    acc  = 0;
  endfunction

  function automatic bma_pkg::bma_out_t filter_step(input bma_pkg::bma_in_t it);
    int unsigned w, half, slot;
    longint      x, avg, res, mid;
    bma_pkg::bma_out_t r;
    w = (width_reg == 0) ? 1 :
        (width_reg > bma_pkg::MAX_WINDOW_DEFAULT) ? bma_pkg::MAX_WINDOW_DEFAULT : width_reg;
    x = longint'($signed(it.sample));
    if (it.restart) forget_history();
    if (head >= w) head = 0;
    if (fill > w) forget_history();
    if (fill == w) begin
      acc = acc + x - longint'(hist[head]);
      hist[head] = it.sample;
      head = (head + 1) % w;
    end else begin
      slot = (head + fill) % w;
      hist[slot] = it.sample;
      fill++;
      acc = acc + x;
    end
    // signed division truncates toward zero
    avg = acc / longint'(fill);
    res = avg;
    if (hp_reg) begin
      half = fill >> 1;
      if ((w % 2) == 0 && fill > 1)
        mid = (longint'(hist[(head + half - 1) % w]) +
               longint'(hist[(head + half) % w])) >>> 1;
      else
        mid = longint'(hist[(head + half) % w]);
      res = mid - avg;
    end
    r.filtered    = res[bma_pkg::OUT_W-1:0];
    r.window_full = (fill == w);
    return r;
  endfunction

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_want = filter_step(cur.item);
        if (cur.known) next_want = cur.want;
        pending_outputs.push_back(next_want);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          cur = sample_queue.pop_front();
          in_data  <= cur.item;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0 && gap_max != 0) begin
            burst_left = $urandom_range(1, 10);
            gap_left   = $urandom_range(1, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result, stalls in alternating runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          got_want = pending_outputs.pop_front();
          checked++;
          if (out_data.filtered !== got_want.filtered)
            flag_mismatch($sformatf("filtered %0d, expected %0d",
                                    out_data.filtered, got_want.filtered));
          if (out_data.window_full !== got_want.window_full)
            flag_mismatch($sformatf("window_full %0b, expected %0b",
                                    out_data.window_full, got_want.window_full));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_max == 0) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, stall_max) : $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [bma_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bma_pkg::REG_WINDOW_WIDTH) begin
      width_reg = value[bma_pkg::WW_W-1:0];
      forget_history();
    end else begin
      hp_reg = value[0];
    end
  endtask

  task automatic read_reg(input logic idx, output logic [bma_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits are random, only the register's own bits must stick
  task automatic apply_settings(input logic [bma_pkg::WW_W-1:0] w, input bit hp,
                                input bit set_width);
    logic [bma_pkg::DATA_W-1:0] data, rd;
    if (set_width) begin
      data = $urandom;
      data[bma_pkg::WW_W-1:0] = w;
      write_reg(bma_pkg::REG_WINDOW_WIDTH, data);
    end
    data = $urandom;
    data[0] = hp;
    write_reg(bma_pkg::REG_HIGH_PASS, data);
    read_reg(bma_pkg::REG_WINDOW_WIDTH, rd);
    if (rd !== bma_pkg::DATA_W'(width_reg))
      flag_mismatch($sformatf("window_width reads %0d, expected %0d", rd, width_reg));
    read_reg(bma_pkg::REG_HIGH_PASS, rd);
    if (rd !== bma_pkg::DATA_W'(hp_reg))
      flag_mismatch($sformatf("high_pass_mode reads %0d, expected %0d", rd, hp_reg));
    settings++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_outputs.size() != 0);
  endtask

  task automatic add_row(input bit set_cfg, input int w, input bit hp, input int s,
                         input bit rs, input bit known, input int filt, input bit full);
    dir_row_t row;
    row.set_cfg = set_cfg;
    row.w       = bma_pkg::WW_W'(w);
    row.hp      = hp;
    row.stim.item.sample       = bma_pkg::SAMPLE_BITS'(s);
    row.stim.item.restart      = rs;
    row.stim.known             = known;
    row.stim.want.filtered     = bma_pkg::OUT_W'(filt);
    row.stim.want.window_full  = full;
    dir_table.push_back(row);
  endtask

  initial begin
    stim_t                    s;
    logic [bma_pkg::WW_W-1:0] w;
    int                       n, phase, rand_cnt;
    phase = 0;
    rand_cnt = 0;
    foreach (hist[i]) hist[i] = '0;
    forget_history();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: width 8, plain average, truncation toward zero
    add_row(0, 8, 0, -32768, 1, 1, -32768, 0);
    add_row(0, 8, 0,  32767, 0, 1,      0, 0);
    add_row(0, 8, 0,     -3, 1, 1,     -3, 0);
    add_row(0, 8, 0,      0, 0, 1,     -1, 0);
    repeat (6) add_row(0, 8, 0, 32767, 0, 0, 0, 0);
    add_row(0, 8, 0, -32768, 0, 0, 0, 0);
    // width zero behaves as one
    add_row(1, 0, 1,  32767, 0, 1, 0, 1);
    add_row(0, 0, 1, -32768, 1, 1, 0, 1);
    // even width, midpoint from the two middle entries
    add_row(1, 2, 1,  32767, 1, 1,  0, 0);
    add_row(0, 2, 1, -32768, 0, 1, -1, 1);
    add_row(0, 2, 1, -32768, 0, 1,  0, 1);
    // widths above the ring size clamp to it
    add_row(1, 127, 0, -32768, 0, 1, -32768, 0);
    repeat (2) add_row(0, 127, 0, -32768, 0, 0, 0, 0);
    add_row(1, 65, 1, 12345, 1, 1, 0, 0);
    add_row(0, 65, 1,    -1, 0, 0, 0, 0);
    // odd width midpoint
    add_row(1, 3, 1, -32768, 1, 1,     0, 0);
    add_row(0, 3, 1,  32767, 0, 1, 32767, 0);
    add_row(0, 3, 1,  32767, 0, 0,     0, 0);
    add_row(0, 3, 1, -32768, 0, 0,     0, 0);

    gap_max   = 8;
    stall_max = 6;
    foreach (dir_table[i]) begin
      if (dir_table[i].set_cfg) begin
        drain();
        apply_settings(dir_table[i].w, dir_table[i].hp, 1'b1);
      end
      sample_queue.push_back(dir_table[i].stim);
    end
    drain();

    while (rand_cnt < 750) begin
      phase++;
      case ($urandom_range(0, 7))
        0:       w = 7'd0;
        1:       w = 7'd1;
        2:       w = 7'd64;
        3:       w = bma_pkg::WW_W'($urandom_range(65, 127));
        4:       w = 7'd2;
        default: w = bma_pkg::WW_W'($urandom_range(1, 16));
      endcase
      apply_settings(w, 1'($urandom_range(0, 1)), phase == 1 || $urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: begin gap_max = 0;  stall_max = 0;  end
        1: begin gap_max = 8;  stall_max = 6;  end
        2: begin gap_max = 40; stall_max = 4;  end
        default: begin gap_max = 4; stall_max = 30; end
      endcase
      // long output hold while items keep coming, so the core backs up
      if (phase % 5 == 4) begin
        gap_max  = 0;
        hold_req = 1'b1;
        holds++;
      end
      n = $urandom_range(60, 100);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       s.item.sample = 16'h8000;
          1:       s.item.sample = 16'h7fff;
          2, 3:    s.item.sample = bma_pkg::SAMPLE_BITS'($urandom_range(0, 64) - 32);
          default: s.item.sample = bma_pkg::SAMPLE_BITS'($urandom);
        endcase
        s.item.restart = ($urandom_range(0, 39) == 0);
        s.known = 1'b0;
        s.want  = '0;
        sample_queue.push_back(s);
        rand_cnt++;
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("ran %0d samples (%0d directed) over %0d register settings, %0d long holds",
             accepted, dir_table.size(), settings, holds);
    $display("%0d results checked, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/bma_pkg.sv
sv/bma_divider.sv
sv/boxcar_moving_average_core.sv
sv/bma_checker.sv
bench/testbench.sv
